>>> src/fdr_pkg.sv
package fdr_pkg;

  localparam int unsigned FRAC_BITS_DEF = 14;

  localparam int unsigned VEC_W = 16;
  localparam int unsigned IDX_W = 16;
  localparam int unsigned CFG_W = 14;
  localparam int unsigned REFL_W = 16;

  // cosine magnitude and sine squared are carried as unsigned Q1.30
  localparam int unsigned COS_W = 31;
  localparam logic [COS_W-1:0] Q30_ONE = 31'h4000_0000;

  // ni^2 (1 - cos^2) and its divisor
  localparam int unsigned LHS_W = 63;
  localparam int unsigned SQ_W = 32;

  // square root operand is (1 - sin^2) << 30
  localparam int unsigned ROOT_X_W = 61;

  // ratio numerator and denominator magnitudes
  localparam int unsigned RAT_W = 48;
  localparam int unsigned RQ_W = 17;
  localparam logic [RQ_W-1:0] RQ_ONE = 17'h1_0000;

  localparam logic [CFG_W-1:0] OUTER_RESET = 14'd4097;
  localparam logic [REFL_W-1:0] R_ONE = 16'h8000;

  typedef struct packed {
    logic tir;
    logic zden;
    logic signed [COS_W:0] c;
    logic [IDX_W-1:0] ni;
    logic [IDX_W-1:0] nt;
  } front_t;

endpackage

>>> src/fdr_front.sv
module fdr_front import fdr_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [VEC_W-1:0] dir_x_i,
  input  logic signed [VEC_W-1:0] dir_y_i,
  input  logic signed [VEC_W-1:0] dir_z_i,
  input  logic signed [VEC_W-1:0] norm_x_i,
  input  logic signed [VEC_W-1:0] norm_y_i,
  input  logic signed [VEC_W-1:0] norm_z_i,
  input  logic [IDX_W-1:0]        mat_i,
  input  logic                    inside_i,
  input  logic [CFG_W-1:0]        outer_i,
  output logic                    valid_o,
  output logic [LHS_W-1:0]        lhs_o,
  output logic [SQ_W-1:0]         ntsq_o,
  output front_t                  side_o
);

  localparam int SHR = (2 * FRAC_BITS >= 30) ? int'(2 * FRAC_BITS) - 30 : 0;
  localparam int SHL = (2 * FRAC_BITS >= 30) ? 0 : 30 - int'(2 * FRAC_BITS);

  logic [5:0] v_q;

  // stage 1: products
  logic signed [2*VEC_W-1:0] p0_q, p1_q, p2_q;
  logic [IDX_W-1:0]          ni1_q, nt1_q;
  logic                      in1_q;

  // stage 2: cosine magnitude, scaled and clamped
  logic signed [33:0]        dot, ci;
  logic [33:0]               mag;
  logic [63:0]               mw;
  logic [COS_W-1:0]          m_d, m_q;
  logic                      neg;
  front_t                    s2_d, s2_q;

  // stages 3 to 6
  logic [2*COS_W-1:0]        c2p_q;
  logic [SQ_W-1:0]           nisq3_q, ntsq3_q, nisq4_q, ntsq4_q, ntsq5_q;
  logic [COS_W-1:0]          s_q;
  logic [LHS_W-1:0]          lhs5_q;
  front_t                    s3_q, s4_q, s5_q;
  front_t                    s6_d;

  always_comb begin
    dot = 34'(p0_q) + 34'(p1_q) + 34'(p2_q);
    ci  = in1_q ? dot : -dot;
    neg = ci[33];
    mag = neg ? 34'(-ci) : 34'(ci);
    mw  = (64'(mag) >> SHR) << SHL;
    m_d = (mw > 64'(Q30_ONE)) ? Q30_ONE : mw[COS_W-1:0];
    s2_d      = '0;
    s2_d.c    = neg ? -$signed({1'b0, m_d}) : $signed({1'b0, m_d});
    s2_d.ni   = ni1_q;
    s2_d.nt   = nt1_q;
  end

  // exact test for total internal reflection
  always_comb begin
    s6_d      = s5_q;
    s6_d.tir  = lhs5_q > {1'b0, ntsq5_q, 30'b0};
    s6_d.zden = ntsq5_q == '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= dir_x_i * norm_x_i;
      p1_q  <= dir_y_i * norm_y_i;
      p2_q  <= dir_z_i * norm_z_i;
      ni1_q <= inside_i ? mat_i : IDX_W'(outer_i);
      nt1_q <= inside_i ? IDX_W'(outer_i) : mat_i;
      in1_q <= inside_i;

      m_q   <= m_d;
      s2_q  <= s2_d;

      c2p_q   <= m_q * m_q;
      nisq3_q <= s2_q.ni * s2_q.ni;
      ntsq3_q <= s2_q.nt * s2_q.nt;
      s3_q    <= s2_q;

      s_q     <= Q30_ONE - c2p_q[60:30];
      nisq4_q <= nisq3_q;
      ntsq4_q <= ntsq3_q;
      s4_q    <= s3_q;

      lhs5_q  <= LHS_W'(nisq4_q) * LHS_W'(s_q);
      ntsq5_q <= ntsq4_q;
      s5_q    <= s4_q;

      lhs_o   <= lhs5_q;
      ntsq_o  <= ntsq5_q;
      side_o  <= s6_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  assign valid_o = v_q[5];

endmodule

>>> src/fdr_div.sv
module fdr_div import fdr_pkg::*; #(
  parameter int unsigned NUM_W = 63,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned Q_W   = 31,
  parameter int unsigned SB_W  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [SB_W-1:0]  sb_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quo_o,
  output logic [SB_W-1:0]  sb_o
);

  localparam int unsigned W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [W-1:0]     rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [SB_W-1:0]  sb_q  [Q_W];
  logic [Q_W-1:0]   v_q;

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int unsigned K = Q_W - 1 - i;
    logic [W-1:0]     rp;
    logic [DEN_W-1:0] dp;
    logic [Q_W-1:0]   qp;
    logic [SB_W-1:0]  sp;
    logic             vp;
    logic [W-1:0]     dsh;
    logic             ge;

    if (i == 0) begin : g_first
      assign rp = W'(num_i);
      assign dp = den_i;
      assign qp = '0;
      assign sp = sb_i;
      assign vp = valid_i;
    end else begin : g_next
      assign rp = rem_q[i-1];
      assign dp = den_q[i-1];
      assign qp = quo_q[i-1];
      assign sp = sb_q[i-1];
      assign vp = v_q[i-1];
    end

    assign dsh = W'(dp) << K;
    assign ge  = rp >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? rp - dsh : rp;
        den_q[i] <= dp;
        quo_q[i] <= qp | (Q_W'(ge) << K);
        sb_q[i]  <= sp;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= vp;
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign sb_o    = sb_q[Q_W-1];

endmodule

>>> src/fdr_sqrt.sv
module fdr_sqrt import fdr_pkg::*; #(
  parameter int unsigned X_W  = ROOT_X_W,
  parameter int unsigned R_W  = COS_W,
  parameter int unsigned SB_W = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [X_W-1:0]  x_i,
  input  logic [SB_W-1:0] sb_i,
  output logic            valid_o,
  output logic [R_W-1:0]  root_o,
  output logic [SB_W-1:0] sb_o
);

  localparam int unsigned TW = 2 * R_W + 1;

  logic [TW-1:0]   rem_q  [R_W];
  logic [R_W-1:0]  root_q [R_W];
  logic [SB_W-1:0] sb_q   [R_W];
  logic [R_W-1:0]  v_q;

  // floor square root, one root bit per stage
  for (genvar i = 0; i < R_W; i++) begin : g_stage
    localparam int unsigned K = R_W - 1 - i;
    logic [TW-1:0]   rp;
    logic [R_W-1:0]  qp;
    logic [SB_W-1:0] sp;
    logic            vp;
    logic [TW-1:0]   trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign rp = TW'(x_i);
      assign qp = '0;
      assign sp = sb_i;
      assign vp = valid_i;
    end else begin : g_next
      assign rp = rem_q[i-1];
      assign qp = root_q[i-1];
      assign sp = sb_q[i-1];
      assign vp = v_q[i-1];
    end

    // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
    assign trial = (TW'(qp) << (K + 1)) | (TW'(1) << (2 * K));
    assign ge    = rp >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? rp - trial : rp;
        root_q[i] <= qp | (R_W'(ge) << K);
        sb_q[i]   <= sp;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= vp;
      end
    end
  end

  assign valid_o = v_q[R_W-1];
  assign root_o  = root_q[R_W-1];
  assign sb_o    = sb_q[R_W-1];

endmodule

>>> src/fdr_ratio.sv
module fdr_ratio import fdr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [COS_W:0]   c_i,
  input  logic [COS_W-1:0]        t_i,
  input  logic [IDX_W-1:0]        ni_i,
  input  logic [IDX_W-1:0]        nt_i,
  input  logic                    tir_i,
  output logic                    valid_o,
  output logic [REFL_W-1:0]       refl_o,
  output logic                    tir_o
);

  localparam int unsigned PW = RAT_W + 1;

  logic [2:0]            va_q;
  logic signed [PW-1:0]  pnc_q, ptc_q, ptt_q, pnt_q;
  logic                  tir_a_q, tir_b_q, tir_c_q;
  logic signed [PW-1:0]  n1, d1, n2, d2;
  logic [RAT_W-1:0]      n1_q, d1_q, n2_q, d2_q;
  logic                  ovf1, ovf2;
  logic [RAT_W-1:0]      n1c_q, d1c_q, n2c_q, d2c_q;

  logic                  dv1, dv2;
  logic [RQ_W-1:0]       q1, q2, q1c, q2c;
  logic [1:0]            sb1;
  logic                  sb2;

  logic [2*RQ_W-1:0]     a_q, b_q;
  logic                  tir_d_q, v_d_q;
  logic [2*RQ_W:0]       sum;
  logic [2*RQ_W-18:0]    r;

  always_comb begin
    n1 = pnc_q - ptt_q;
    d1 = pnc_q + ptt_q;
    n2 = ptc_q - pnt_q;
    d2 = ptc_q + pnt_q;
    // a zero denominator or a ratio of two or more is capped at one
    ovf1 = (d1c_q == '0) || ({1'b0, n1c_q} >= {d1c_q, 1'b0});
    ovf2 = (d2c_q == '0) || ({1'b0, n2c_q} >= {d2c_q, 1'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pnc_q   <= PW'($signed({1'b0, ni_i})) * PW'(c_i);
      ptc_q   <= PW'($signed({1'b0, nt_i})) * PW'(c_i);
      ptt_q   <= $signed(PW'(nt_i) * PW'(t_i));
      pnt_q   <= $signed(PW'(ni_i) * PW'(t_i));
      tir_a_q <= tir_i;

      n1_q    <= n1[PW-1] ? RAT_W'(-n1) : RAT_W'(n1);
      d1_q    <= d1[PW-1] ? RAT_W'(-d1) : RAT_W'(d1);
      n2_q    <= n2[PW-1] ? RAT_W'(-n2) : RAT_W'(n2);
      d2_q    <= d2[PW-1] ? RAT_W'(-d2) : RAT_W'(d2);
      tir_b_q <= tir_a_q;

      n1c_q   <= n1_q;
      d1c_q   <= d1_q;
      n2c_q   <= n2_q;
      d2c_q   <= d2_q;
      tir_c_q <= tir_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
    end else if (en_i) begin
      va_q <= {va_q[1:0], valid_i};
    end
  end

  fdr_div #(
    .NUM_W (RAT_W + 16),
    .DEN_W (RAT_W),
    .Q_W   (RQ_W),
    .SB_W  (2)
  ) u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (va_q[2]),
    .num_i   ({n1c_q, 16'b0}),
    .den_i   (d1c_q),
    .sb_i    ({tir_c_q, ovf1}),
    .valid_o (dv1),
    .quo_o   (q1),
    .sb_o    (sb1)
  );

  fdr_div #(
    .NUM_W (RAT_W + 16),
    .DEN_W (RAT_W),
    .Q_W   (RQ_W),
    .SB_W  (1)
  ) u_div_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (va_q[2]),
    .num_i   ({n2c_q, 16'b0}),
    .den_i   (d2c_q),
    .sb_i    (ovf2),
    .valid_o (dv2),
    .quo_o   (q2),
    .sb_o    (sb2)
  );

  assign q1c = (sb1[0] || q1 > RQ_ONE) ? RQ_ONE : q1;
  assign q2c = (sb2 || q2 > RQ_ONE) ? RQ_ONE : q2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q     <= q1c * q1c;
      b_q     <= q2c * q2c;
      tir_d_q <= sb1[1];
    end
  end

  assign sum = {1'b0, a_q} + {1'b0, b_q};
  assign r   = sum[2*RQ_W:18];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      refl_o <= (tir_d_q || r > (2*RQ_W-17)'(R_ONE)) ? R_ONE : REFL_W'(r);
      tir_o  <= tir_d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_d_q   <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v_d_q   <= dv1 & dv2;
      valid_o <= v_d_q;
    end
  end

endmodule

>>> src/fresnel_dielectric_reflectance.sv
// channel  | valid        | ready        | payload
// ---------+--------------+--------------+------------------------------------------
// input    | in_valid_i   | in_ready_o   | dir_*_i, norm_*_i, material_index_i,
//          |              |              | inside_req_i
// result   | out_valid_o  | out_ready_i  | reflectance_o, total_internal_o
// config   | cfg_valid_i  | cfg_ready_o  | cfg_data_i (outer_index)
//
// one item per cycle while no result is parked in the skid register
// most pipeline stages are in the bit-per-stage units: 31-stage quotient for sin^2,
// 31-stage square root, then 17-stage ratio dividers
// reset clears valid bits and loads outer_index with air
// a stalled result parks in a skid register; the pipeline then holds as a whole
module fresnel_dielectric_reflectance import fdr_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [VEC_W-1:0] dir_x_i,
  input  logic signed [VEC_W-1:0] dir_y_i,
  input  logic signed [VEC_W-1:0] dir_z_i,
  input  logic signed [VEC_W-1:0] norm_x_i,
  input  logic signed [VEC_W-1:0] norm_y_i,
  input  logic signed [VEC_W-1:0] norm_z_i,
  input  logic [IDX_W-1:0]        material_index_i,
  input  logic                    inside_req_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [REFL_W-1:0]       reflectance_o,
  output logic                    total_internal_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  logic [CFG_W-1:0]  outer_q;
  logic              en;
  logic              skid_q, skid_d;
  logic [REFL_W-1:0] skid_refl_q;
  logic              skid_tir_q;

  logic              fv;
  logic [LHS_W-1:0]  lhs;
  logic [SQ_W-1:0]   ntsq;
  front_t            fside, dside, rside;
  logic              dv, rv, lv;
  logic [COS_W-1:0]  sin2_raw, sin2, root;
  logic [ROOT_X_W-1:0] root_x;
  logic [REFL_W-1:0] lrefl;
  logic              ltir;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q <= OUTER_RESET;
    end else if (cfg_valid_i) begin
      outer_q <= cfg_data_i;
    end
  end

  assign en         = !skid_q;
  assign in_ready_o = en;

  fdr_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .dir_x_i  (dir_x_i),
    .dir_y_i  (dir_y_i),
    .dir_z_i  (dir_z_i),
    .norm_x_i (norm_x_i),
    .norm_y_i (norm_y_i),
    .norm_z_i (norm_z_i),
    .mat_i    (material_index_i),
    .inside_i (inside_req_i),
    .outer_i  (outer_q),
    .valid_o  (fv),
    .lhs_o    (lhs),
    .ntsq_o   (ntsq),
    .side_o   (fside)
  );

  fdr_div #(
    .NUM_W (LHS_W),
    .DEN_W (SQ_W),
    .Q_W   (COS_W),
    .SB_W  ($bits(front_t))
  ) u_div_sin2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .num_i   (lhs),
    .den_i   (ntsq),
    .sb_i    (fside),
    .valid_o (dv),
    .quo_o   (sin2_raw),
    .sb_o    (dside)
  );

  // zero transmitted index without total reflection means sin^2 of zero
  assign sin2   = dside.zden ? '0 : sin2_raw;
  assign root_x = {Q30_ONE - sin2, 30'b0};

  fdr_sqrt #(
    .X_W  (ROOT_X_W),
    .R_W  (COS_W),
    .SB_W ($bits(front_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv),
    .x_i     (root_x),
    .sb_i    (dside),
    .valid_o (rv),
    .root_o  (root),
    .sb_o    (rside)
  );

  fdr_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rv),
    .c_i     (rside.c),
    .t_i     (root),
    .ni_i    (rside.ni),
    .nt_i    (rside.nt),
    .tir_i   (rside.tir),
    .valid_o (lv),
    .refl_o  (lrefl),
    .tir_o   (ltir)
  );

  always_comb begin
    if (skid_q) begin
      skid_d = !out_ready_i;
    end else begin
      skid_d = lv && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else begin
      skid_q <= skid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_q) begin
      skid_refl_q <= lrefl;
      skid_tir_q  <= ltir;
    end
  end

  assign out_valid_o      = skid_q || lv;
  assign reflectance_o    = skid_q ? skid_refl_q : lrefl;
  assign total_internal_o = skid_q ? skid_tir_q : ltir;

  a_tir_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && total_internal_o |-> reflectance_o == R_ONE)
    else $error("total reflection item without full reflectance");

  a_refl_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> reflectance_o <= R_ONE)
    else $error("reflectance above one");

  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input held off with no item waiting");

  a_skid_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q && out_ready_i |=> !skid_q)
    else $error("skid register not released after take");

endmodule

>>> tb/fresnel_reflectance_checker.sv
`timescale 1ns / 100ps
module fresnel_reflectance_checker import fdr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic signed [VEC_W-1:0] dir_x_i,
  input  logic signed [VEC_W-1:0] dir_y_i,
  input  logic signed [VEC_W-1:0] dir_z_i,
  input  logic signed [VEC_W-1:0] norm_x_i,
  input  logic signed [VEC_W-1:0] norm_y_i,
  input  logic signed [VEC_W-1:0] norm_z_i,
  input  logic [IDX_W-1:0]        material_index_i,
  input  logic                    inside_req_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [REFL_W-1:0]       reflectance_i,
  input  logic                    total_internal_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      tir_seen_o,
  output int                      results_seen_o
);

  typedef struct packed {
    logic [REFL_W-1:0] refl;
    logic              tir;
  } hit_result_t;

  hit_result_t expected_q[$];
  logic [CFG_W-1:0] outer_idx;

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] amp_ratio_sq(longint num, longint den);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] q;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    if (d == 0) return 64'd1 << 32;
    q = (n << 16) / d;
    if (q > 64'h1_0000) q = 64'h1_0000;
    return q * q;
  endfunction

  function automatic hit_result_t fresnel_predict(
      logic signed [15:0] dx, logic signed [15:0] dy, logic signed [15:0] dz,
      logic signed [15:0] nx, logic signed [15:0] ny, logic signed [15:0] nz,
      logic [15:0] mat, logic inside_ray, logic [CFG_W-1:0] outer);
    longint dot;
    longint ci;
    longint c;
    longint t;
    longint ni;
    longint nt;
    logic [63:0] m;
    logic [63:0] c2;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [63:0] sin2;
    logic [63:0] r;
    logic neg;
    hit_result_t res;
    dot = longint'(dx) * nx + longint'(dy) * ny + longint'(dz) * nz;
    ni = inside_ray ? longint'(mat) : longint'(outer);
    nt = inside_ray ? longint'(outer) : longint'(mat);
    ci = inside_ray ? dot : -dot;
    neg = ci < 0;
    m = neg ? -ci : ci;
    m = m << 2;
    if (m > 64'h4000_0000) m = 64'h4000_0000;
    c = neg ? -longint'(m) : longint'(m);
    c2 = (m * m) >> 30;
    lhs = ni * ni * (64'h4000_0000 - c2);
    rhs = (nt * nt) << 30;
    if (lhs > rhs) begin
      res.refl = R_ONE;
      res.tir = 1'b1;
      return res;
    end
    sin2 = (nt != 0) ? lhs / (nt * nt) : 0;
    if (sin2 > 64'h4000_0000) sin2 = 64'h4000_0000;
    t = longint'(floor_sqrt((64'h4000_0000 - sin2) << 30));
    r = (amp_ratio_sq(ni * c - nt * t, ni * c + nt * t)
       + amp_ratio_sq(nt * c - ni * t, nt * c + ni * t)) >> 18;
    if (r > 64'd32768) r = 64'd32768;
    res.refl = r[15:0];
    res.tir = 1'b0;
    return res;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    hit_result_t exp_r;
    if (!rst_ni) begin
      outer_idx <= OUTER_RESET;
      expected_q.delete();
      fail_count_o <= 0;
      tir_seen_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        expected_q.push_back(fresnel_predict(dir_x_i, dir_y_i, dir_z_i, norm_x_i,
            norm_y_i, norm_z_i, material_index_i, inside_req_i, outer_idx));
      if (cfg_valid_i && cfg_ready_i) outer_idx <= cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (total_internal_i) tir_seen_o <= tir_seen_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result with no item outstanding: refl %0d tir %0b",
                   $time, reflectance_i, total_internal_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.refl !== reflectance_i || exp_r.tir !== total_internal_i) begin
            $display("%0t: mismatch expected refl %0d tir %0b, actual refl %0d tir %0b",
                     $time, exp_r.refl, exp_r.tir, reflectance_i, total_internal_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/fresnel_dielectric_reflectance_tb.sv
`timescale 1ns / 100ps
module fresnel_dielectric_reflectance_tb import fdr_pkg::*;;

  localparam int LATENCY = 90;
  localparam int N_RANDOM = 1030;
  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [VEC_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [VEC_W-1:0] norm_x = '0, norm_y = '0, norm_z = '0;
  logic [IDX_W-1:0] mat_idx = 16'd4096;
  logic inside_req = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [REFL_W-1:0] refl;
  logic tir;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = OUTER_RESET;
  int fail_count, pending, tir_seen, results_seen;
  int idle_cycles = 0;
  int items_sent = 0;
  bit hold_off = 1'b0;

  always #5 clk_i = ~clk_i;

  fresnel_dielectric_reflectance DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .dir_x_i(dir_x), .dir_y_i(dir_y), .dir_z_i(dir_z),
    .norm_x_i(norm_x), .norm_y_i(norm_y), .norm_z_i(norm_z),
    .material_index_i(mat_idx), .inside_req_i(inside_req),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .reflectance_o(refl), .total_internal_o(tir),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  fresnel_reflectance_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .dir_x_i(dir_x), .dir_y_i(dir_y), .dir_z_i(dir_z),
    .norm_x_i(norm_x), .norm_y_i(norm_y), .norm_z_i(norm_z),
    .material_index_i(mat_idx), .inside_req_i(inside_req),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .reflectance_i(refl), .total_internal_i(tir),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending),
    .tir_seen_o(tir_seen), .results_seen_o(results_seen)
  );

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // receiver: random stalls, one long hold-off while the sender keeps going
  always @(posedge clk_i) begin
    int n;
    if (rst_ni) begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        n = gap_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_hit(logic signed [15:0] dx, logic signed [15:0] dy,
                          logic signed [15:0] dz, logic signed [15:0] nx,
                          logic signed [15:0] ny, logic signed [15:0] nz,
                          logic [15:0] m, logic ins, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    dir_x <= dx; dir_y <= dy; dir_z <= dz;
    norm_x <= nx; norm_y <= ny; norm_z <= nz;
    mat_idx <= m; inside_req <= ins;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain_and_set_outer(logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // unit-ish random vector pair with the normal near +z; one draw in ten is fully random
  task automatic random_hit(bit gaps);
    logic signed [15:0] v[6];
    logic [15:0] m;
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      foreach (v[i]) v[i] = 16'($urandom);
    end else begin
      v[0] = 16'($urandom_range(0, 32767) - 16384);
      v[1] = 16'($urandom_range(0, 32767) - 16384);
      v[2] = (k < 5) ? 16'(-16384 + int'($urandom_range(0, 6000)))
                     : 16'($urandom_range(0, 32767) - 16384);
      v[3] = 16'($urandom_range(0, 4000) - 2000);
      v[4] = 16'($urandom_range(0, 4000) - 2000);
      v[5] = 16'(16384 - int'($urandom_range(0, 3000)));
    end
    m = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(4096, 12000));
    send_hit(v[0], v[1], v[2], v[3], v[4], v[5], m, 1'($urandom_range(0, 1)), gaps);
  endtask

  localparam logic [CFG_W-1:0] OUTER_SET[4] = '{14'd4096, 14'd16383, 14'd6144, 14'd5461};

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // head-on, grazing, extremes, zero index, reversed normal, non-unit
    send_hit(0, 0, -16384, 0, 0, 16384, 16'd6144, 0, 0);
    send_hit(0, 0, -16384, 0, 0, 16384, 16'd6144, 1, 0);
    send_hit(16384, 0, 0, 0, 0, 16384, 16'd6144, 0, 0);
    send_hit(11585, 0, -11585, 0, 0, 16384, 16'd6144, 1, 0);
    send_hit(14000, 0, -8000, 0, 0, 16384, 16'd12000, 1, 0);
    send_hit(0, 0, 16384, 0, 0, 16384, 16'd6144, 0, 0);
    send_hit(-32768, -32768, -32768, 32767, 32767, 32767, 16'hFFFF, 0, 0);
    send_hit(32767, 32767, 32767, 32767, 32767, 32767, 16'hFFFF, 1, 0);
    send_hit(-32768, -32768, -32768, -32768, -32768, -32768, 16'd4096, 0, 0);
    send_hit(0, 0, 0, 0, 0, 0, 16'd4096, 0, 0);
    send_hit(0, 0, 0, 0, 0, 0, 16'd0, 0, 0);
    send_hit(16384, 0, 0, 0, 0, 16384, 16'd0, 0, 0);
    send_hit(0, 0, -16384, 0, 0, 16384, 16'd0, 1, 0);
    send_hit(0, 0, -16384, 0, 0, 16384, 16'd4097, 0, 0);
    send_hit(-5000, 3000, -15000, 0, 0, 16384, 16'hAAAA, 0, 0);
    send_hit(5000, -3000, -15000, 0, 0, 16384, 16'h5555, 1, 0);
    foreach (OUTER_SET[s]) begin
      drain_and_set_outer(OUTER_SET[s]);
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        if (s == 1 && i == 20) hold_off = 1'b1;
        random_hit(i % 100 < 80);
      end
    end
    drain_and_set_outer(OUTER_RESET);
    for (int i = 0; i < N_RANDOM / 5; i++) random_hit(1);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("sent %0d hits over %0d index settings, %0d results, %0d total internal",
             items_sent, 5, results_seen, tir_seen);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
